>>> rtl/swbb_pkg.sv
// ----------------------------------------------------------------------------
// swbb_pkg
// Shared constants and widths for the sliding-window Bollinger band block.
// ----------------------------------------------------------------------------
package swbb_pkg;

	localparam int MAX_WINDOW   = 256;
	localparam int SAMPLE_WIDTH = 24;
	localparam int ADDR_W       = $clog2(MAX_WINDOW);
	localparam int LEN_W        = 9;
	localparam int GAIN_W       = 16;
	localparam int BAND_W       = 28;
	localparam int SUM_W        = 32;
	localparam int SQ_W         = 55;

	// bit-serial unit sizes
	localparam int MUL_A_W   = 64;
	localparam int MUL_B_W   = 32;
	localparam int DIV_W     = 40;
	localparam int DIV_STEPS = 40;
	localparam int SQRT_STEPS = 32;

	// register indexes
	localparam logic [1:0] REG_WINDOW_LENGTH = 2'd0;
	localparam logic [1:0] REG_GAIN_UP       = 2'd1;
	localparam logic [1:0] REG_GAIN_DOWN     = 2'd2;

	localparam logic [LEN_W-1:0] LEN_RESET  = 9'd20;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd8192;

endpackage

>>> rtl/swbb_ram.sv
// ----------------------------------------------------------------------------
// swbb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module swbb_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/swbb_mul.sv
// ----------------------------------------------------------------------------
// swbb_mul
// Shift-and-add multiplier, one multiplier bit per cycle, stops early.
// ----------------------------------------------------------------------------
module swbb_mul
	import swbb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [MUL_A_W-1:0] a,
	input  logic [MUL_B_W-1:0] b,
	output logic               done,
	output logic [MUL_A_W-1:0] prod
);

	logic               busy_q;
	logic [MUL_A_W-1:0] a_q;
	logic [MUL_B_W-1:0] b_q;
	logic [MUL_A_W-1:0] acc_q;

	assign done = busy_q && (b_q == '0);
	assign prod = acc_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	// datapath: add the shifted multiplicand for each set bit
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q && !done) begin
			if (b_q[0]) begin
				acc_q <= acc_q + a_q;
			end
			a_q <= {a_q[MUL_A_W-2:0], 1'b0};
			b_q <= {1'b0, b_q[MUL_B_W-1:1]};
		end
	end

endmodule

>>> rtl/swbb_sqrt.sv
// ----------------------------------------------------------------------------
// swbb_sqrt
// Integer square root, one result bit (two radicand bits) per cycle.
// ----------------------------------------------------------------------------
module swbb_sqrt
	import swbb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [MUL_A_W-1:0] radicand,
	output logic               done,
	output logic [MUL_B_W-1:0] root
);

	logic               busy_q;
	logic [5:0]         cnt_q;
	logic [MUL_A_W-1:0] x_q;
	logic [MUL_A_W-1:0] res_q;
	logic [MUL_A_W-1:0] bit_q;
	logic [MUL_A_W-1:0] trial;
	logic               ge;

	assign trial = res_q + bit_q;
	assign ge    = x_q >= trial;
	assign done  = busy_q && (cnt_q == 6'(SQRT_STEPS));
	assign root  = res_q[MUL_B_W-1:0];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
		end
	end

	// restoring root step
	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= radicand;
			res_q <= '0;
			bit_q <= {2'b01, {(MUL_A_W-2){1'b0}}};
		end else if (busy_q && !done) begin
			if (ge) begin
				x_q   <= x_q - trial;
				res_q <= {1'b0, res_q[MUL_A_W-1:1]} + bit_q;
			end else begin
				res_q <= {1'b0, res_q[MUL_A_W-1:1]};
			end
			bit_q <= {2'b00, bit_q[MUL_A_W-1:2]};
		end
	end

endmodule

>>> rtl/swbb_div.sv
// ----------------------------------------------------------------------------
// swbb_div
// Restoring divider by the window length, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module swbb_div
	import swbb_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [LEN_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient
);

	logic             busy_q;
	logic [5:0]       cnt_q;
	logic [DIV_W-1:0] quo_q;
	logic [LEN_W-1:0] rem_q;
	logic [LEN_W-1:0] dvs_q;
	logic [LEN_W:0]   rem_sh;
	logic [LEN_W:0]   rem_sub;
	logic             ge;

	assign rem_sh   = {rem_q, quo_q[DIV_W-1]};
	assign ge       = rem_sh >= {1'b0, dvs_q};
	assign rem_sub  = rem_sh - {1'b0, dvs_q};
	assign done     = busy_q && (cnt_q == 6'(DIV_STEPS));
	assign quotient = quo_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 6'd1;
		end
	end

	// shift one dividend bit into the remainder per step
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q && !done) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= ge ? rem_sub[LEN_W-1:0] : rem_sh[LEN_W-1:0];
		end
	end

endmodule

>>> rtl/sliding_window_bollinger_bands.sv
// A sample that only fills the window is squared and added to the sums; one that
// gives a result then goes through the shared bit-serial multiplier (one bit per
// cycle, stops early), the 32-step root and three 40-step divides.
// Throughput: one sample at a time; the next is taken when its sums are updated or,
// with a result, once that is parked in the output register. Reset clears registers
// to reset values, empties the window; the sample store is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
// sliding_window_bollinger_bands
// Running sum and sum of squares over a ring of samples; mean and deviation
// bands computed with shared serial multiply and divide units and a serial root unit.
// ----------------------------------------------------------------------------
module sliding_window_bollinger_bands
	import swbb_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic                      restart,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [BAND_W-1:0]  upper_band,
	output logic signed [SAMPLE_WIDTH-1:0] middle_band,
	output logic signed [BAND_W-1:0]  lower_band,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [1:0]                cfg_index,
	input  logic [31:0]               cfg_data
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SQX  = 4'd1;
	localparam logic [3:0] S_SQO  = 4'd2;
	localparam logic [3:0] S_NSQ  = 4'd3;
	localparam logic [3:0] S_SS   = 4'd4;
	localparam logic [3:0] S_SQRT = 4'd5;
	localparam logic [3:0] S_MID  = 4'd6;
	localparam logic [3:0] S_GU   = 4'd7;
	localparam logic [3:0] S_DU   = 4'd8;
	localparam logic [3:0] S_GD   = 4'd9;
	localparam logic [3:0] S_DD   = 4'd10;
	localparam logic [3:0] S_FIN  = 4'd11;

	logic [3:0]              state_q;
	logic                    issued_q;
	logic [LEN_W-1:0]        len_q;
	logic [GAIN_W-1:0]       gain_up_q;
	logic [GAIN_W-1:0]       gain_dn_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0]         sumsq_q;
	logic [LEN_W-1:0]        fill_q;
	logic [ADDR_W-1:0]       wp_q;
	logic [SAMPLE_WIDTH-1:0] mx_q;
	logic signed [SAMPLE_WIDTH-1:0] x_q;
	logic                    full_q;
	logic                    res_q;
	logic [MUL_A_W-1:0]      p1_q;
	logic [MUL_A_W-1:0]      d_q;
	logic [MUL_B_W-1:0]      root_q;
	logic [MUL_A_W-1:0]      gprod_q;
	logic [SAMPLE_WIDTH-1:0] mid_q;
	logic [BAND_W-1:0]       offu_q;
	logic [BAND_W-1:0]       offd_q;
	logic                    out_valid_q;
	logic [BAND_W-1:0]       upper_q;
	logic [SAMPLE_WIDTH-1:0] middle_q;
	logic [BAND_W-1:0]       lower_q;

	logic [LEN_W-1:0]        n_eff;
	logic                    in_acc;
	logic                    cfg_acc;
	logic [LEN_W-1:0]        fill_b;
	logic [ADDR_W-1:0]       wp_b;
	logic [ADDR_W-1:0]       wp_eff;
	logic [LEN_W-1:0]        wp_inc;
	logic                    full_b;
	logic [LEN_W-1:0]        fill_nx;
	logic [SAMPLE_WIDTH-1:0] old_w;
	logic [SAMPLE_WIDTH-1:0] mo;
	logic [SUM_W-1:0]        sum_mag;
	logic [GAIN_W-1:0]       gu_mag;
	logic [GAIN_W-1:0]       gd_mag;
	logic                    unit_go;
	logic                    mul_start;
	logic                    div_start;
	logic                    sqrt_start;
	logic [MUL_A_W-1:0]      mul_a;
	logic [MUL_B_W-1:0]      mul_b;
	logic [MUL_A_W-1:0]      mul_p;
	logic                    mul_done;
	logic [DIV_W-1:0]        div_n;
	logic [DIV_W-1:0]        div_q;
	logic                    div_done;
	logic [MUL_B_W-1:0]      sqrt_r;
	logic                    sqrt_done;
	logic                    out_load;
	logic [BAND_W-1:0]       mid_ext;

	// effective window length, clamped to 2..MAX_WINDOW
	always_comb begin
		n_eff = len_q;
		if (len_q < LEN_W'(2)) begin
			n_eff = LEN_W'(2);
		end else if (len_q > LEN_W'(MAX_WINDOW)) begin
			n_eff = LEN_W'(MAX_WINDOW);
		end
	end

	assign in_stall  = state_q != S_IDLE;
	assign in_acc    = in_valid && !in_stall;
	// register writes only while idle and no sample beat is offered
	assign cfg_ready = (state_q == S_IDLE) && !in_valid;
	assign cfg_acc   = cfg_valid && cfg_ready;

	// ring position and fill for the incoming beat
	assign fill_b  = restart ? '0 : fill_q;
	assign wp_b    = restart ? '0 : wp_q;
	assign wp_eff  = ({1'b0, wp_b} >= n_eff) ? '0 : wp_b;
	assign wp_inc  = {1'b0, wp_eff} + LEN_W'(1);
	assign full_b  = fill_b >= n_eff;
	assign fill_nx = full_b ? fill_b : fill_b + LEN_W'(1);

	swbb_ram #(
		.WIDTH(SAMPLE_WIDTH),
		.DEPTH(MAX_WINDOW)
	) u_store (
		.clk  (clk),
		.we   (in_acc),
		.waddr(wp_eff),
		.wdata(sample),
		.re   (in_acc && full_b),
		.raddr(wp_eff),
		.rdata(old_w)
	);

	// magnitudes
	assign mo      = old_w[SAMPLE_WIDTH-1] ? -old_w : old_w;
	assign sum_mag = sum_q[SUM_W-1] ? -sum_q : sum_q;
	assign gu_mag  = gain_up_q[GAIN_W-1] ? -gain_up_q : gain_up_q;
	assign gd_mag  = gain_dn_q[GAIN_W-1] ? -gain_dn_q : gain_dn_q;

	// unit start on the first cycle of each compute state
	assign unit_go    = !issued_q;
	assign mul_start  = unit_go && (state_q == S_SQX || state_q == S_SQO ||
		state_q == S_NSQ || state_q == S_SS || state_q == S_GU || state_q == S_GD);
	assign div_start  = unit_go && (state_q == S_MID || state_q == S_DU ||
		state_q == S_DD);
	assign sqrt_start = unit_go && (state_q == S_SQRT);

	// operand selection
	always_comb begin
		mul_a = MUL_A_W'(mx_q);
		mul_b = MUL_B_W'(mx_q);
		div_n = DIV_W'(sum_mag);
		case (state_q)
			S_SQO: begin
				mul_a = MUL_A_W'(mo);
				mul_b = MUL_B_W'(mo);
			end
			S_NSQ: begin
				mul_a = MUL_A_W'(sumsq_q);
				mul_b = MUL_B_W'(n_eff);
			end
			S_SS: begin
				mul_a = MUL_A_W'(sum_mag);
				mul_b = sum_mag;
			end
			S_GU: begin
				mul_a = MUL_A_W'(root_q);
				mul_b = MUL_B_W'(gu_mag);
			end
			S_GD: begin
				mul_a = MUL_A_W'(root_q);
				mul_b = MUL_B_W'(gd_mag);
			end
			default: begin
			end
		endcase
		if (state_q == S_DU || state_q == S_DD) begin
			div_n = gprod_q[DIV_W+11:12];
		end
	end

	swbb_mul u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (mul_a),
		.b     (mul_b),
		.done  (mul_done),
		.prod  (mul_p)
	);

	swbb_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sqrt_start),
		.radicand(d_q),
		.done    (sqrt_done),
		.root    (sqrt_r)
	);

	swbb_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_n),
		.divisor (n_eff),
		.done    (div_done),
		.quotient(div_q)
	);

	assign out_load = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	// sequencer, window state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			issued_q  <= 1'b0;
			len_q     <= LEN_RESET;
			gain_up_q <= GAIN_RESET;
			gain_dn_q <= GAIN_RESET;
			sum_q     <= '0;
			sumsq_q   <= '0;
			fill_q    <= '0;
			wp_q      <= '0;
			full_q    <= 1'b0;
			res_q     <= 1'b0;
		end else begin
			if (cfg_acc) begin
				unique case (cfg_index)
					REG_WINDOW_LENGTH: begin
						len_q   <= cfg_data[LEN_W-1:0];
						sum_q   <= '0;
						sumsq_q <= '0;
						fill_q  <= '0;
						wp_q    <= '0;
					end
					REG_GAIN_UP:   gain_up_q <= cfg_data[GAIN_W-1:0];
					REG_GAIN_DOWN: gain_dn_q <= cfg_data[GAIN_W-1:0];
					default: begin
					end
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (restart) begin
							sum_q   <= '0;
							sumsq_q <= '0;
						end
						fill_q   <= fill_nx;
						wp_q     <= (wp_inc >= n_eff) ? '0 : wp_inc[ADDR_W-1:0];
						full_q   <= full_b;
						res_q    <= fill_nx >= n_eff;
						issued_q <= 1'b0;
						state_q  <= S_SQX;
					end
				end
				S_SQX: begin
					issued_q <= 1'b1;
					if (issued_q && mul_done) begin
						sumsq_q  <= sumsq_q + mul_p[SQ_W-1:0];
						sum_q    <= sum_q + SUM_W'(x_q);
						issued_q <= 1'b0;
						state_q  <= full_q ? S_SQO : (res_q ? S_NSQ : S_IDLE);
					end
				end
				S_SQO: begin
					issued_q <= 1'b1;
					if (issued_q && mul_done) begin
						sumsq_q  <= sumsq_q - mul_p[SQ_W-1:0];
						sum_q    <= sum_q - SUM_W'(signed'(old_w));
						issued_q <= 1'b0;
						state_q  <= S_NSQ;
					end
				end
				S_NSQ: begin
					issued_q <= 1'b1;
					if (issued_q && mul_done) begin
						issued_q <= 1'b0;
						state_q  <= S_SS;
					end
				end
				S_SS: begin
					issued_q <= 1'b1;
					if (issued_q && mul_done) begin
						issued_q <= 1'b0;
						state_q  <= S_SQRT;
					end
				end
				S_SQRT: begin
					issued_q <= 1'b1;
					if (issued_q && sqrt_done) begin
						issued_q <= 1'b0;
						state_q  <= S_MID;
					end
				end
				S_MID: begin
					issued_q <= 1'b1;
					if (issued_q && div_done) begin
						issued_q <= 1'b0;
						state_q  <= S_GU;
					end
				end
				S_GU: begin
					issued_q <= 1'b1;
					if (issued_q && mul_done) begin
						issued_q <= 1'b0;
						state_q  <= S_DU;
					end
				end
				S_DU: begin
					issued_q <= 1'b1;
					if (issued_q && div_done) begin
						issued_q <= 1'b0;
						state_q  <= S_GD;
					end
				end
				S_GD: begin
					issued_q <= 1'b1;
					if (issued_q && mul_done) begin
						issued_q <= 1'b0;
						state_q  <= S_DD;
					end
				end
				S_DD: begin
					issued_q <= 1'b1;
					if (issued_q && div_done) begin
						issued_q <= 1'b0;
						state_q  <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// per-beat datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q  <= sample;
			mx_q <= sample[SAMPLE_WIDTH-1] ? -sample : sample;
		end
		if (issued_q && mul_done && state_q == S_NSQ) begin
			p1_q <= mul_p;
		end
		if (issued_q && mul_done && state_q == S_SS) begin
			d_q <= p1_q - mul_p;
		end
		if (issued_q && sqrt_done) begin
			root_q <= sqrt_r;
		end
		if (issued_q && mul_done && (state_q == S_GU || state_q == S_GD)) begin
			gprod_q <= mul_p;
		end
		if (issued_q && div_done) begin
			case (state_q)
				S_MID: mid_q <= sum_q[SUM_W-1] ? -div_q[SAMPLE_WIDTH-1:0]
					: div_q[SAMPLE_WIDTH-1:0];
				S_DU: offu_q <= gain_up_q[GAIN_W-1] ? -div_q[BAND_W-1:0]
					: div_q[BAND_W-1:0];
				S_DD: offd_q <= gain_dn_q[GAIN_W-1] ? -div_q[BAND_W-1:0]
					: div_q[BAND_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// output register
	assign mid_ext = {{(BAND_W-SAMPLE_WIDTH){mid_q[SAMPLE_WIDTH-1]}}, mid_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			upper_q  <= mid_ext + offu_q;
			middle_q <= mid_q;
			lower_q  <= mid_ext - offd_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign upper_band  = upper_q;
	assign middle_band = middle_q;
	assign lower_band  = lower_q;

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= n_eff)
		else $error("fill count exceeds window length");

	a_wp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, wp_q} < n_eff)
		else $error("write pointer outside ring");

	a_empty_sums: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == '0 && state_q == S_IDLE) |-> (sum_q == '0 && sumsq_q == '0))
		else $error("sums nonzero on empty window");

	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_FIN)
		else $error("result raised outside final step");

endmodule
